// ===== design/rmd_pkg.sv =====
package rmd_pkg;

  // Opcode field and its codes.
  localparam int OPCODE_W = 2;
  localparam logic [OPCODE_W-1:0] OP_MUL = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DIV = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CMP = 2'd2;

  // Result field widths.
  localparam int OUT_NUM_W = 32;
  localparam int OUT_DEN_W = 31;

  // Status of the shared divider as the sequencer sees it.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/rmd_in_if.sv =====
interface rmd_in_if #(
  parameter int W = 16
);
  logic                           valid;
  logic                           ready;
  logic [rmd_pkg::OPCODE_W-1:0]   opcode;
  logic signed [W-1:0]            a_num;
  logic [W-2:0]                   a_den;
  logic signed [W-1:0]            b_num;
  logic [W-2:0]                   b_den;

  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== design/rmd_out_if.sv =====
interface rmd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmd_pkg::OUT_NUM_W-1:0] res_num;
  logic [rmd_pkg::OUT_DEN_W-1:0]        res_den;
  logic                                 equal_flag;
  logic                                 div_zero;

  modport source (output valid, res_num, res_den, equal_flag, div_zero, input ready);
  modport sink   (input valid, res_num, res_den, equal_flag, div_zero, output ready);
endinterface

// ===== design/rmd_div.sv =====
// Restoring divider, one quotient bit per cycle. It gives quotient and
// remainder of an unsigned division and holds them until the next start.
module rmd_div #(
  parameter int P = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [P-1:0]      dividend,
  input  logic [P-1:0]      divisor,
  output rmd_pkg::div_stat_t stat,
  output logic [P-1:0]      quot,
  output logic [P-1:0]      rem
);
  localparam int CW = $clog2(P + 1);

  logic [P-1:0]  rem_r, rem_nxt;
  logic [P-1:0]  quo_r, quo_nxt;
  logic [P-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [P:0]    shifted;
  logic [P:0]    diff;
  logic          fits;

  // One trial subtraction of the shifted partial remainder.
  assign shifted = {rem_r, quo_r[P-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign fits    = ~diff[P];

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      rem_nxt = fits ? diff[P-1:0] : shifted[P-1:0];
      quo_nxt = {quo_r[P-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(P);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;
  assign rem       = rem_r;

endmodule

// ===== design/rational_mul_div_reduce.sv =====
// Channel  Dir  Handshake          Payload
// in_ch    in   valid/ready        opcode, a_num, a_den, b_num, b_den
// out_ch   out  valid/ready        res_num, res_den, equal_flag, div_zero
//
// Compare, the unused opcode, division by a zero fraction, zero denominators and zero
// results pass through S_MUL1, S_MUL2, S_EVAL and S_FINISH. Multiply and divide also
// run Euclid remainder steps on the shared bit-serial divider, then divide numerator
// and denominator by the common divisor on the same divider.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the
// output register. A result waiting on out_ch lets the next request in, but
// that request finishes only once the output register is free.
module rational_mul_div_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input logic      clk,
  input logic      rst_n,
  rmd_in_if.sink   in_ch,
  rmd_out_if.source out_ch
);
  localparam int W  = OPERAND_WIDTH;
  localparam int P  = 2 * W;
  localparam int XW = P + rmd_pkg::OUT_NUM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_EVAL, S_GCD, S_GWAIT, S_QNUM, S_QDEN, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // Operand registers, kept as sign and magnitude.
  logic [rmd_pkg::OPCODE_W-1:0] op_r, op_nxt;
  logic [W-1:0] an_r, an_nxt, bn_r, bn_nxt;
  logic [W-2:0] ad_r, ad_nxt, bd_r, bd_nxt;
  logic         an_neg_r, an_neg_nxt, bn_neg_r, bn_neg_nxt;

  // Cross products and Euclid working pair.
  logic [P-1:0] nm_r, nm_nxt, dn_r, dn_nxt;
  logic [P-1:0] x_r, x_nxt, y_r, y_nxt, g_r, g_nxt, qn_r, qn_nxt;

  // Finished result and output register.
  logic [rmd_pkg::OUT_NUM_W-1:0] res_num_r, res_num_nxt;
  logic [rmd_pkg::OUT_DEN_W-1:0] res_den_r, res_den_nxt;
  logic res_eq_r, res_eq_nxt, res_dz_r, res_dz_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [rmd_pkg::OUT_NUM_W-1:0] out_num_r, out_num_nxt;
  logic [rmd_pkg::OUT_DEN_W-1:0] out_den_r, out_den_nxt;
  logic out_eq_r, out_eq_nxt, out_dz_r, out_dz_nxt;

  // Magnitudes of the incoming numerators.
  logic [W-1:0] a_mag, b_mag;
  assign a_mag = in_ch.a_num[W-1] ? (~in_ch.a_num + 1'b1) : in_ch.a_num;
  assign b_mag = in_ch.b_num[W-1] ? (~in_ch.b_num + 1'b1) : in_ch.b_num;

  // Shared multiplier, one product per cycle.
  logic [W-1:0] mul_x, mul_y;
  logic [P-1:0] prod;

  always_comb begin
    mul_x = an_r;
    mul_y = {1'b0, bd_r};
    if (state_r == S_MUL1) begin
      mul_x = an_r;
      mul_y = (op_r == rmd_pkg::OP_MUL) ? bn_r : {1'b0, bd_r};
    end else begin
      mul_x = {1'b0, ad_r};
      mul_y = (op_r == rmd_pkg::OP_MUL) ? {1'b0, bd_r} : bn_r;
    end
  end

  assign prod = P'(mul_x) * P'(mul_y);

  // Shared divider for Euclid remainders and the final reduction.
  logic         div_start;
  logic [P-1:0] div_dvd, div_dsr, div_quot, div_rem;
  rmd_pkg::div_stat_t div_stat;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = x_r;
    div_dsr   = y_r;
    case (state_r)
      S_GCD: begin
        div_start = 1'b1;
        if (y_r == '0) begin
          div_dvd = nm_r;
          div_dsr = x_r;
        end
      end
      S_QNUM: begin
        div_start = div_stat.done;
        div_dvd   = dn_r;
        div_dsr   = g_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rmd_div #(.P(P)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Signed numerator and denominator of the reduced result.
  logic [XW-1:0] qn_ext, qn_signed, qd_ext;
  assign qn_ext    = XW'(qn_r);
  assign qn_signed = (an_neg_r != bn_neg_r) ? (~qn_ext + 1'b1) : qn_ext;
  assign qd_ext    = XW'(div_quot);

  logic nm_nz, dn_nz;
  assign nm_nz = |nm_r;
  assign dn_nz = |dn_r;

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    an_nxt      = an_r;
    bn_nxt      = bn_r;
    ad_nxt      = ad_r;
    bd_nxt      = bd_r;
    an_neg_nxt  = an_neg_r;
    bn_neg_nxt  = bn_neg_r;
    nm_nxt      = nm_r;
    dn_nxt      = dn_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    g_nxt       = g_r;
    qn_nxt      = qn_r;
    res_num_nxt = res_num_r;
    res_den_nxt = res_den_r;
    res_eq_nxt  = res_eq_r;
    res_dz_nxt  = res_dz_r;
    out_num_nxt = out_num_r;
    out_den_nxt = out_den_r;
    out_eq_nxt  = out_eq_r;
    out_dz_nxt  = out_dz_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = in_ch.opcode;
          an_nxt     = a_mag;
          bn_nxt     = b_mag;
          ad_nxt     = in_ch.a_den;
          bd_nxt     = in_ch.b_den;
          an_neg_nxt = in_ch.a_num[W-1];
          bn_neg_nxt = in_ch.b_num[W-1];
          state_nxt  = S_MUL1;
        end
      end
      S_MUL1: begin
        nm_nxt    = prod;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        dn_nxt    = prod;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // Most cases end here with 0/1 and only the flags differing.
        res_num_nxt = '0;
        res_den_nxt = rmd_pkg::OUT_DEN_W'(1);
        res_eq_nxt  = 1'b0;
        res_dz_nxt  = 1'b0;
        state_nxt   = S_FINISH;
        case (op_r)
          rmd_pkg::OP_CMP: begin
            res_eq_nxt = (nm_r == dn_r) &&
                         ((an_neg_r && nm_nz) == (bn_neg_r && dn_nz));
          end
          rmd_pkg::OP_MUL, rmd_pkg::OP_DIV: begin
            if (op_r == rmd_pkg::OP_DIV && bn_r == '0) begin
              res_dz_nxt = 1'b1;
            end else if (!nm_nz) begin
              res_dz_nxt = 1'b0;
            end else if (!dn_nz) begin
              res_dz_nxt = 1'b1;
            end else begin
              x_nxt     = nm_r;
              y_nxt     = dn_r;
              state_nxt = S_GCD;
            end
          end
          default: begin
            res_dz_nxt = 1'b0;
          end
        endcase
      end
      S_GCD: begin
        // A zero remainder leaves the divisor in x; start the numerator division.
        if (y_r == '0) begin
          g_nxt     = x_r;
          state_nxt = S_QNUM;
        end else begin
          state_nxt = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (div_stat.done) begin
          x_nxt     = y_r;
          y_nxt     = div_rem;
          state_nxt = S_GCD;
        end
      end
      S_QNUM: begin
        if (div_stat.done) begin
          qn_nxt    = div_quot;
          state_nxt = S_QDEN;
        end
      end
      S_QDEN: begin
        if (div_stat.done) begin
          res_num_nxt = qn_signed[rmd_pkg::OUT_NUM_W-1:0];
          res_den_nxt = qd_ext[rmd_pkg::OUT_DEN_W-1:0];
          res_eq_nxt  = 1'b0;
          res_dz_nxt  = 1'b0;
          state_nxt   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_num_nxt   = res_num_r;
          out_den_nxt   = res_den_r;
          out_eq_nxt    = res_eq_r;
          out_dz_nxt    = res_dz_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    an_r      <= an_nxt;
    bn_r      <= bn_nxt;
    ad_r      <= ad_nxt;
    bd_r      <= bd_nxt;
    an_neg_r  <= an_neg_nxt;
    bn_neg_r  <= bn_neg_nxt;
    nm_r      <= nm_nxt;
    dn_r      <= dn_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    g_r       <= g_nxt;
    qn_r      <= qn_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    res_eq_r  <= res_eq_nxt;
    res_dz_r  <= res_dz_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
    out_eq_r  <= out_eq_nxt;
    out_dz_r  <= out_dz_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.res_num    = out_num_r;
  assign out_ch.res_den    = out_den_r;
  assign out_ch.equal_flag = out_eq_r;
  assign out_ch.div_zero   = out_dz_r;

endmodule

// ===== tb/sv/rmd_checker.sv =====
module rmd_checker #(
  parameter int W = 16
) (
  input  logic clk,
  input  logic rst_n,
  rmd_in_if    in_mon,
  rmd_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [rmd_pkg::OUT_NUM_W-1:0] num;
    logic [rmd_pkg::OUT_DEN_W-1:0]        den;
    logic                                 eq;
    logic                                 dz;
  } rmd_result_t;

  // Results predicted for accepted requests, oldest first.
  rmd_result_t fraction_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Computes the reduced product, quotient or equality verdict of two fractions.
  function automatic rmd_result_t predict_rational(
    logic [rmd_pkg::OPCODE_W-1:0] op,
    logic signed [W-1:0] an,
    logic [W-2:0]        ad,
    logic signed [W-1:0] bn,
    logic [W-2:0]        bd
  );
    rmd_result_t     r;
    bit              a_neg;
    bit              b_neg;
    bit              neg;
    bit              lneg;
    bit              rneg;
    longint unsigned am;
    longint unsigned bm;
    longint unsigned nm;
    longint unsigned dn;
    longint unsigned x;
    longint unsigned y;
    longint unsigned rem;
    longint unsigned q;
    longint unsigned lhs;
    longint unsigned rhs;
    r.num = '0;
    r.den = rmd_pkg::OUT_DEN_W'(1);
    r.eq  = 1'b0;
    r.dz  = 1'b0;
    a_neg = an[W-1];
    b_neg = bn[W-1];
    am = a_neg ? longint'(-longint'(an)) : longint'(an);
    bm = b_neg ? longint'(-longint'(bn)) : longint'(bn);
    case (op)
      rmd_pkg::OP_CMP: begin
        // Cross products keep their sign only when they are nonzero.
        lhs  = am * bd;
        rhs  = bm * ad;
        lneg = a_neg && (lhs != 0);
        rneg = b_neg && (rhs != 0);
        r.eq = (lhs == rhs) && (lneg == rneg);
      end
      rmd_pkg::OP_MUL, rmd_pkg::OP_DIV: begin
        if (op == rmd_pkg::OP_DIV && bm == 0) begin
          r.dz = 1'b1;
        end else begin
          if (op == rmd_pkg::OP_MUL) begin
            nm = am * bm;
            dn = ad * bd;
          end else begin
            nm = am * bd;
            dn = ad * bm;
          end
          neg = a_neg ^ b_neg;
          if (nm == 0) begin
            // A zero numerator always comes out as 0/1.
          end else if (dn == 0) begin
            r.dz = 1'b1;
          end else begin
            // Euclid's remainder loop for the common divisor.
            x = nm;
            y = dn;
            while (y != 0) begin
              rem = x % y;
              x   = y;
              y   = rem;
            end
            q = nm / x;
            if (neg) q = -q;
            r.num = q[rmd_pkg::OUT_NUM_W-1:0];
            q = dn / x;
            r.den = q[rmd_pkg::OUT_DEN_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Predict on every accepted request and compare every accepted result.
  always @(posedge clk) begin : watch
    rmd_result_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        fraction_q.push_back(predict_rational(in_mon.opcode, in_mon.a_num, in_mon.a_den,
                                              in_mon.b_num, in_mon.b_den));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (fraction_q.size() == 0) begin
          report_mismatch("result with no request pending", longint'(out_mon.res_num), 0);
        end else begin
          want = fraction_q.pop_front();
          if (out_mon.res_num !== want.num)
            report_mismatch("res_num", longint'(out_mon.res_num), longint'(want.num));
          if (out_mon.res_den !== want.den)
            report_mismatch("res_den", longint'(out_mon.res_den), longint'(want.den));
          if (out_mon.equal_flag !== want.eq)
            report_mismatch("equal_flag", longint'(out_mon.equal_flag), longint'(want.eq));
          if (out_mon.div_zero !== want.dz)
            report_mismatch("div_zero", longint'(out_mon.div_zero), longint'(want.dz));
        end
      end
    end
    pending = fraction_q.size();
  end

endmodule

// ===== tb/sv/tb_rational_mul_div_reduce.sv =====
module tb_rational_mul_div_reduce;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 16;
  localparam logic [rmd_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam int N_ITEMS     = 900;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 3000;
  localparam int PAUSE_AT    = 600;
  localparam int CALM_AT     = 780;
  localparam int DRAIN_LIMIT = 200000;
  localparam int TAIL_CYCLES = 2000;

  logic clk = 1'b0;
  logic rst_n;
  int   sent_count = 0;
  int   fail_count;
  int   pending;

  rmd_in_if #(.W(W)) in_ch ();
  rmd_out_if         out_ch ();

  rational_mul_div_reduce #(.OPERAND_WIDTH(W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rmd_checker #(.W(W)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  // Idling is allowed in two of every three stretches and stops near the end.
  function automatic bit idle_allowed(int n);
    return (n < CALM_AT) && ((n / 120) % 3 != 2);
  endfunction

  function automatic logic signed [W-1:0] rand_num();
    logic signed [W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 16'sh8000;
          1: v = 16'sh7fff;
          2: v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      2, 3, 4, 5: v = W'($urandom_range(0, 64)) - 16'sd32;
      default: v = W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [W-2:0] rand_den();
    logic [W-2:0] v;
    case ($urandom_range(0, 19))
      0: v = '0;
      1: v = '1;
      2, 3, 4, 5, 6, 7, 8, 9: v = (W-1)'($urandom_range(1, 64));
      default: v = (W-1)'($urandom);
    endcase
    return v;
  endfunction

  // Offers one request at the falling edge and holds it until it is taken.
  task automatic send_request(logic [rmd_pkg::OPCODE_W-1:0] op, logic signed [W-1:0] an,
                              logic [W-2:0] ad, logic signed [W-1:0] bn,
                              logic [W-2:0] bd);
    @(negedge clk);
    in_ch.valid  = 1'b1;
    in_ch.opcode = op;
    in_ch.a_num  = an;
    in_ch.a_den  = ad;
    in_ch.b_num  = bn;
    in_ch.b_den  = bd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  // Drops valid for a random burst, but only where idling is allowed.
  task automatic maybe_gap();
    int n;
    if (idle_allowed(sent_count) && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Fraction pairs with random content, some built to compare equal.
  task automatic send_random();
    logic [rmd_pkg::OPCODE_W-1:0] op;
    logic signed [W-1:0] an;
    logic signed [W-1:0] bn;
    logic [W-2:0]        ad;
    logic [W-2:0]        bd;
    int                  k;
    case ($urandom_range(0, 15))
      0: op = OP_UNUSED;
      1, 2, 3, 4, 5, 6: op = rmd_pkg::OP_MUL;
      7, 8, 9, 10, 11, 12: op = rmd_pkg::OP_DIV;
      default: op = rmd_pkg::OP_CMP;
    endcase
    an = rand_num();
    ad = rand_den();
    bn = rand_num();
    bd = rand_den();
    if (op == rmd_pkg::OP_CMP && $urandom_range(0, 1) == 1) begin
      k  = $urandom_range(1, 100);
      an = W'($urandom_range(0, 400)) - 16'sd200;
      ad = (W-1)'($urandom_range(1, 200));
      bn = an * W'(k);
      bd = ad * (W-1)'(k);
    end
    send_request(op, an, ad, bn, bd);
  endtask

  // Result side: random back-pressure bursts and one long hold-off.
  initial begin : receiver
    bit held;
    int n;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready = 1'b0;
      end else if (sent_count >= HOLD_AT && !held) begin
        held = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (idle_allowed(sent_count) && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        out_ch.ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Reset, directed cases, random requests, then drain and verdict.
  initial begin : stimulus
    int drain;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = rmd_pkg::OP_MUL;
    in_ch.a_num  = '0;
    in_ch.a_den  = '0;
    in_ch.b_num  = '0;
    in_ch.b_den  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Largest magnitudes, zero numerators and zero denominators.
    send_request(rmd_pkg::OP_MUL, 16'sh8000, 15'd1, 16'sh8000, 15'd1);
    send_request(rmd_pkg::OP_MUL, 16'sh7fff, 15'd1, 16'sh8000, 15'h7fff);
    send_request(rmd_pkg::OP_MUL, 16'sd0, 15'd5, -16'sd7, 15'd3);
    send_request(rmd_pkg::OP_MUL, 16'sd3, 15'd0, 16'sd5, 15'd7);
    send_request(rmd_pkg::OP_MUL, 16'sd1, 15'h7fff, -16'sd1, 15'h7fff);
    send_request(rmd_pkg::OP_MUL, -16'sd1, 15'd1, -16'sd1, 15'd1);
    // Division by a zero fraction, including zero over zero.
    send_request(rmd_pkg::OP_DIV, 16'sd5, 15'd3, 16'sd0, 15'd7);
    send_request(rmd_pkg::OP_DIV, 16'sd0, 15'd1, 16'sd0, 15'd1);
    send_request(rmd_pkg::OP_DIV, 16'sd0, 15'd3, 16'sd2, 15'd5);
    send_request(rmd_pkg::OP_DIV, 16'sh8000, 15'd1, 16'sd1, 15'h7fff);
    send_request(rmd_pkg::OP_DIV, 16'sd7, 15'd0, 16'sd3, 15'd2);
    send_request(rmd_pkg::OP_DIV, -16'sd3, 15'd4, -16'sd9, 15'd8);
    send_request(rmd_pkg::OP_DIV, 16'sh7fff, 15'd1, 16'sh8000, 15'd1);
    send_request(rmd_pkg::OP_DIV, 16'sd12, 15'd35, 16'sd4, 15'd15);
    // Equality by cross products, with signs, zeros and zero denominators.
    send_request(rmd_pkg::OP_CMP, 16'sd1, 15'd2, 16'sd2, 15'd4);
    send_request(rmd_pkg::OP_CMP, -16'sd1, 15'd2, 16'sd1, 15'd2);
    send_request(rmd_pkg::OP_CMP, 16'sd0, 15'd3, 16'sd0, 15'd7);
    send_request(rmd_pkg::OP_CMP, 16'sd5, 15'd0, 16'sd7, 15'd0);
    send_request(rmd_pkg::OP_CMP, 16'sh8000, 15'h7fff, 16'sh8000, 15'h7fff);
    send_request(rmd_pkg::OP_CMP, 16'sh7fff, 15'd1, 16'sh8000, 15'd1);
    // The unused opcode.
    send_request(OP_UNUSED, 16'sh7fff, 15'h7fff, 16'sh8000, 15'h7fff);
    send_request(OP_UNUSED, 16'sd0, 15'd0, 16'sd0, 15'd0);

    while (sent_count < N_ITEMS) begin
      if (sent_count == PAUSE_AT) begin
        // Let the block run dry before going on.
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end else begin
        maybe_gap();
      end
      send_random();
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
